>>> src/dual_moving_average_hex_telemetry_core_macros.svh
// assertion macros shared by the telemetry core modules
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef DUAL_MOVING_AVERAGE_HEX_TELEMETRY_CORE_MACROS_SVH
`define DUAL_MOVING_AVERAGE_HEX_TELEMETRY_CORE_MACROS_SVH

// same-cycle implication
`define DMAHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DMAHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dmaht_pkg.sv
// shared constants, types and frame byte functions for the telemetry core
// no dependencies
`timescale 1ns / 1ps

package dmaht_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int WIN_DEPTH  = 16;
    localparam int WIN_AW     = $clog2(WIN_DEPTH);
    localparam int SUM_W      = SAMPLE_W + WIN_AW;
    localparam int POS_W      = 4;
    localparam int BYTE_W     = 8;

    localparam logic [POS_W-1:0]  FULL_FRAME  = 4'd10;
    localparam logic [BYTE_W-1:0] CHAR_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CHAR_Q      = 8'h51;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_LETTER = 8'h37;
    localparam logic [3:0]        NIBBLE_TEN  = 4'd10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] avg0;
        logic [SAMPLE_W-1:0] avg1;
    } t_avg_pair;

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] d);
        logic [BYTE_W-1:0] d_ext;
        d_ext = {4'h0, d};
        if (d < NIBBLE_TEN) begin
            return CHAR_ZERO + d_ext;
        end else begin
            return CHAR_LETTER + d_ext;
        end
    endfunction

    function automatic logic [BYTE_W-1:0] frame_byte(input logic [POS_W-1:0] pos,
                                                     input t_avg_pair avg);
        logic [BYTE_W-1:0] res;
        case (pos)
            4'd0:    res = CHAR_P;
            4'd1:    res = hex_char(avg.avg0[15:12]);
            4'd2:    res = hex_char(avg.avg0[11:8]);
            4'd3:    res = hex_char(avg.avg0[7:4]);
            4'd4:    res = hex_char(avg.avg0[3:0]);
            4'd5:    res = CHAR_Q;
            4'd6:    res = hex_char(avg.avg1[15:12]);
            4'd7:    res = hex_char(avg.avg1[11:8]);
            4'd8:    res = hex_char(avg.avg1[7:4]);
            4'd9:    res = hex_char(avg.avg1[3:0]);
            default: res = CHAR_P;
        endcase
        return res;
    endfunction

endpackage

>>> src/dual_moving_average_hex_telemetry_core.sv
// top level: dual 16-tap moving average with ascii hex telemetry frames
// depends on dmaht_pkg, dmaht_avg, dmaht_frame
//
//  channel   direction  payload
//  s_axis    in         tdata[15:0] sample_ch0, tdata[31:16] sample_ch1
//  m_axis    out        tdata[7:0] tx_byte, tlast frame_last
//  cfg       in         data[3:0] frame_bytes
//
// one byte leaves per cycle while m_axis is ready; the byte serializer sends
// min(frame_bytes, 10) bytes per item. the average stage holds one finished item, so the
// next sample transfer overlaps the current frame. synchronous reset clears the
// windows through per-entry valid bits. output stalls hold the serializer and
// back-pressure s_axis once the average stage is full.
`timescale 1ns / 1ps

module dual_moving_average_hex_telemetry_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // sample_ch0, sample_ch1
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // tx_byte
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data        // frame_bytes
);
    import dmaht_pkg::*;

    logic [POS_W-1:0] r_frame_bytes;
    logic [POS_W-1:0] count;
    logic             avg_valid;
    logic             take;
    t_avg_pair        avg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= FULL_FRAME;
        end else if (i_cfg_valid) begin
            r_frame_bytes <= i_cfg_data;
        end
    end

    // lengths above a full frame saturate
    assign count = (r_frame_bytes > FULL_FRAME) ? FULL_FRAME : r_frame_bytes;

    dmaht_avg u_avg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_sample_ch0 (i_s_axis_tdata[15:0]),
        .i_sample_ch1 (i_s_axis_tdata[31:16]),
        .o_avg_valid  (avg_valid),
        .o_avg        (avg),
        .i_take       (take)
    );

    dmaht_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_count     (count),
        .i_avg_valid (avg_valid),
        .i_avg       (avg),
        .o_take      (take),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

endmodule

>>> src/dmaht_avg.sv
// ring windows, running sums and the registered average pair
// depends on dmaht_pkg and the core assertion macros
`timescale 1ns / 1ps
`include "dual_moving_average_hex_telemetry_core_macros.svh"

module dmaht_avg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [dmaht_pkg::SAMPLE_W-1:0]  i_sample_ch0,
    input  logic [dmaht_pkg::SAMPLE_W-1:0]  i_sample_ch1,
    output logic                            o_avg_valid,
    output dmaht_pkg::t_avg_pair            o_avg,
    input  logic                            i_take
);
    import dmaht_pkg::*;

    logic [SAMPLE_W-1:0] r_win0 [WIN_DEPTH];
    logic [SAMPLE_W-1:0] r_win1 [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] r_win_vld;
    logic [SUM_W-1:0]    r_sum0, r_sum1, n_sum0, n_sum1;
    logic [WIN_AW-1:0]   r_cursor, n_cursor;
    logic                r_avg_vld;
    t_avg_pair           r_avg;
    logic [SAMPLE_W-1:0] old0, old1;
    logic                accept;

    assign o_ready = !r_avg_vld || i_take;
    assign accept  = i_valid && o_ready;

    // entries never written since reset read as zero
    assign old0 = r_win_vld[r_cursor] ? r_win0[r_cursor] : '0;
    assign old1 = r_win_vld[r_cursor] ? r_win1[r_cursor] : '0;

    assign n_sum0   = r_sum0 - SUM_W'(old0) + SUM_W'(i_sample_ch0);
    assign n_sum1   = r_sum1 - SUM_W'(old1) + SUM_W'(i_sample_ch1);
    assign n_cursor = (r_cursor == WIN_AW'(WIN_DEPTH - 1)) ? '0 : r_cursor + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_vld <= '0;
            r_sum0    <= '0;
            r_sum1    <= '0;
            r_cursor  <= '0;
            r_avg_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_win_vld[r_cursor] <= 1'b1;
                r_sum0              <= n_sum0;
                r_sum1              <= n_sum1;
                r_cursor            <= n_cursor;
                r_avg_vld           <= 1'b1;
            end else if (i_take) begin
                r_avg_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win0[r_cursor] <= i_sample_ch0;
            r_win1[r_cursor] <= i_sample_ch1;
            r_avg.avg0       <= n_sum0[SUM_W-1 -: SAMPLE_W];
            r_avg.avg1       <= n_sum1[SUM_W-1 -: SAMPLE_W];
        end
    end

    assign o_avg_valid = r_avg_vld;
    assign o_avg       = r_avg;

    `DMAHT_ASSERT_NOW(a_take_has_data, i_take, r_avg_vld, "average taken while empty")
    `DMAHT_ASSERT_NEXT(a_cursor_wrap, accept && (r_cursor == WIN_AW'(WIN_DEPTH - 1)),
                       r_cursor == '0, "write cursor failed to wrap")
    `DMAHT_ASSERT_NEXT(a_accept_fills, accept, r_avg_vld && r_win_vld[$past(r_cursor)],
                       "accepted sample not held")

endmodule

>>> src/dmaht_frame.sv
// frame serializer: walks the ascii telemetry frame one byte per transfer
// depends on dmaht_pkg and the core assertion macros
`timescale 1ns / 1ps
`include "dual_moving_average_hex_telemetry_core_macros.svh"

module dmaht_frame (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [dmaht_pkg::POS_W-1:0]         i_count,
    input  logic                                i_avg_valid,
    input  dmaht_pkg::t_avg_pair                i_avg,
    output logic                                o_take,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [dmaht_pkg::BYTE_W-1:0]        o_byte,
    output logic                                o_last
);
    import dmaht_pkg::*;

    logic             r_busy;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_cnt;
    t_avg_pair        r_avg;
    logic             xfer;
    logic             last;

    assign last    = (r_pos == r_cnt - 1'b1);
    assign xfer    = r_busy && i_ready;
    assign o_take  = i_avg_valid && (!r_busy || (xfer && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else begin
            if (o_take) begin
                r_busy <= (i_count != '0);
                r_pos  <= '0;
            end else if (xfer) begin
                if (last) begin
                    r_busy <= 1'b0;
                end
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_avg <= i_avg;
            r_cnt <= i_count;
        end
    end

    assign o_valid = r_busy;
    assign o_byte  = frame_byte(r_pos, r_avg);
    assign o_last  = last;

    `DMAHT_ASSERT_NOW(a_pos_in_frame, r_busy, r_pos < r_cnt, "byte position past frame")
    `DMAHT_ASSERT_NEXT(a_frame_ends, xfer && last && !o_take, !r_busy,
                       "serializer busy after last byte")
    `DMAHT_ASSERT_NEXT(a_frame_starts, o_take && (i_count != '0), r_busy && (r_pos == '0),
                       "new frame did not start at first byte")

endmodule

>>> bench/dual_moving_average_hex_telemetry_core_tb.sv
// self-checking bench for the dual moving average telemetry core: sample pairs go in on
// s_axis, a predictor of both windows builds the expected ascii frame bytes for m_axis
// depends on dmaht_pkg and dual_moving_average_hex_telemetry_core
`timescale 1ns / 1ps

module dual_moving_average_hex_telemetry_core_tb;
    import dmaht_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int SETTLE_CYCLES   = 16;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int PHASE_ITEMS     = 15;

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              last;
    } t_frame_char;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] s_tdata;          // sample_ch0, sample_ch1
    logic        o_m_axis_tvalid;
    logic        m_tready;
    logic [7:0]  o_m_axis_tdata;   // tx_byte
    logic        o_m_axis_tlast;
    logic        cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  cfg_data;         // frame_bytes

    t_frame_char           expected_chars[$];
    logic [SAMPLE_W-1:0]   win_ch0 [WIN_DEPTH];
    logic [SAMPLE_W-1:0]   win_ch1 [WIN_DEPTH];
    logic [SUM_W-1:0]      run_sum0;
    logic [SUM_W-1:0]      run_sum1;
    logic [WIN_AW-1:0]     cursor;
    logic [3:0]            frame_len;

    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int stall_count;

    dual_moving_average_hex_telemetry_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic logic [BYTE_W-1:0] ascii_nibble(input logic [3:0] n);
        if (n < NIBBLE_TEN) begin
            return CHAR_ZERO + {4'h0, n};
        end else begin
            return CHAR_LETTER + {4'h0, n};
        end
    endfunction

    function automatic void predict_frame(input logic [SAMPLE_W-1:0] s0,
                                          input logic [SAMPLE_W-1:0] s1);
        logic [SAMPLE_W-1:0] avg0;
        logic [SAMPLE_W-1:0] avg1;
        logic [BYTE_W-1:0]   ch;
        int                  count;
        t_frame_char         item;
        run_sum0 = run_sum0 - win_ch0[cursor] + s0;
        run_sum1 = run_sum1 - win_ch1[cursor] + s1;
        win_ch0[cursor] = s0;
        win_ch1[cursor] = s1;
        cursor = cursor + 1'b1;
        avg0 = SAMPLE_W'(run_sum0 / WIN_DEPTH);
        avg1 = SAMPLE_W'(run_sum1 / WIN_DEPTH);
        count = int'((frame_len > FULL_FRAME) ? FULL_FRAME : frame_len);
        for (int k = 0; k < count; k++) begin
            if (k == 0) begin
                ch = CHAR_P;
            end else if (k == 5) begin
                ch = CHAR_Q;
            end else if (k < 5) begin
                ch = ascii_nibble(avg0[(4 - k) * 4 +: 4]);
            end else begin
                ch = ascii_nibble(avg1[(9 - k) * 4 +: 4]);
            end
            item.tx_byte = ch;
            item.last    = (k + 1 == count);
            expected_chars.push_back(item);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    task automatic send_samples(input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s1, s0};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_frame(s0, s1);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_len(input logic [3:0] len);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        frame_len = len;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(255));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic test_reset_frame();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_samples(16'h0000, 16'h0000);
        send_samples(16'hFFFF, 16'h0000);
        send_samples(16'h0000, 16'hFFFF);
        send_samples(16'hFFFF, 16'hFFFF);
        send_samples(16'hABCD, 16'h1234);
        send_samples(16'hFEDC, 16'hBA98);
        send_samples(16'h5678, 16'h9ABC);
        send_samples(16'hFFFF, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_frame_lengths();
        logic [3:0] lengths [8] = '{4'd1, 4'd5, 4'd6, 4'd9, 4'd0, 4'd11, 4'd15, 4'd10};
        foreach (lengths[i]) begin
            write_frame_len(lengths[i]);
            send_samples(pick_sample(), pick_sample());
            send_samples(pick_sample(), pick_sample());
            wait_idle();
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [3:0] len_a, input logic [3:0] len_b);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_frame_len(len_a);
        repeat (PHASE_ITEMS) send_samples(pick_sample(), pick_sample());
        wait_idle();
        write_frame_len(len_b);
        repeat (PHASE_ITEMS) send_samples(pick_sample(), pick_sample());
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_frame_len(FULL_FRAME);
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (WIN_DEPTH) send_samples(16'hFFFF, 16'hFFFF);
        wait_idle();
        repeat (4) send_samples(16'h0000, 16'h0000);
        wait_idle();
    endtask

    // receiver: random idling plus a counted hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_frame_char want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected byte", o_m_axis_tdata, 8'h00);
            end else begin
                want = expected_chars.pop_front();
                if (o_m_axis_tdata !== want.tx_byte) begin
                    report_mismatch("tx_byte", o_m_axis_tdata, want.tx_byte);
                end
                if (o_m_axis_tlast !== want.last) begin
                    report_mismatch("frame_last", {7'd0, o_m_axis_tlast}, {7'd0, want.last});
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)
                || (cfg_valid && o_cfg_ready)) begin
            stall_count = 0;
        end else begin
            stall_count++;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        errors        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 0;
        stall_count   = 0;
        run_sum0      = '0;
        run_sum1      = '0;
        cursor        = '0;
        frame_len     = FULL_FRAME;
        foreach (win_ch0[i]) begin
            win_ch0[i] = '0;
            win_ch1[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_frame();
        test_frame_lengths();
        test_random_traffic(12, 84, FULL_FRAME, 4'($urandom_range(15)));
        test_random_traffic(84, 12, 4'd1, 4'($urandom_range(15)));
        test_random_traffic(0, 0, 4'($urandom_range(15)), 4'd0);
        test_backpressure();
        wait_idle();

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/dmaht_pkg.sv
src/dmaht_avg.sv
src/dmaht_frame.sv
src/dual_moving_average_hex_telemetry_core.sv
bench/dual_moving_average_hex_telemetry_core_tb.sv
